### rtl/tsg_pkg.sv
// ----------------------------------------------------------------------------
// Tetrahedron shape gradients: shared package
// Payload types, datapath widths and the lane result type.
// ----------------------------------------------------------------------------
package tsg_pkg;

   localparam int COORD_BITS    = 16;
   localparam int GRAD_BITS     = 32;
   localparam int SIXV_BITS     = 51;
   localparam int DEF_FRAC_BITS = 24;

   // datapath widths
   localparam int DIFF_W = COORD_BITS + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int COF_W  = 2 * DIFF_W + 1;
   localparam int TERM_W = 3 * DIFF_W + 1;
   localparam int DET_W  = 3 * DIFF_W + 3;
   localparam int VOL_W  = 3 * DIFF_W + 2;
   localparam int QUOT_W = GRAD_BITS + 1;

   localparam logic [1:0] LAST_NODE = 2'd3;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] node0_x;
      logic signed [COORD_BITS-1:0] node0_y;
      logic signed [COORD_BITS-1:0] node0_z;
      logic signed [COORD_BITS-1:0] node1_x;
      logic signed [COORD_BITS-1:0] node1_y;
      logic signed [COORD_BITS-1:0] node1_z;
      logic signed [COORD_BITS-1:0] node2_x;
      logic signed [COORD_BITS-1:0] node2_y;
      logic signed [COORD_BITS-1:0] node2_z;
      logic signed [COORD_BITS-1:0] node3_x;
      logic signed [COORD_BITS-1:0] node3_y;
      logic signed [COORD_BITS-1:0] node3_z;
   } tsg_req_type;

   typedef struct packed {
      logic [1:0]                  node_index;
      logic signed [GRAD_BITS-1:0] grad_x;
      logic signed [GRAD_BITS-1:0] grad_y;
      logic signed [GRAD_BITS-1:0] grad_z;
      logic [SIXV_BITS-1:0]        six_volume;
      logic                        degenerate;
      logic                        saturated;
      logic                        last;
   } tsg_rsp_type;

   // what one divider lane hands to the merge stage
   typedef struct packed {
      logic [QUOT_W-1:0] q2;
      logic              sticky;
      logic              neg;
   } tsg_quot_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] idx;
   } tsg_ctl_type;

endpackage

### rtl/tsg_div_lane.sv
// ----------------------------------------------------------------------------
// Tetrahedron shape gradients: divider lane
// Pipelined restoring divider, one quotient bit per stage, on a cofactor
// magnitude scaled by 2^(FRAC_BITS+1).
// ----------------------------------------------------------------------------
module tsg_div_lane #(
   parameter int FRAC_BITS = tsg_pkg::DEF_FRAC_BITS
) (
   input  logic                        clock,
   input  logic                        adv,
   input  logic [tsg_pkg::COF_W-1:0]   mag_in,
   input  logic                        sign_in,
   input  logic [tsg_pkg::VOL_W-1:0]   den_in [tsg_pkg::COF_W + FRAC_BITS + 1],
   output tsg_pkg::tsg_quot_type       quot_out
);
   import tsg_pkg::*;

   localparam int NSTG = COF_W + FRAC_BITS + 1;

   logic [VOL_W-1:0]  rem_ff [NSTG];
   logic [VOL_W-1:0]  rem_in [NSTG];
   logic [COF_W-1:0]  num_ff [NSTG];
   logic [COF_W-1:0]  num_in [NSTG];
   logic [QUOT_W-1:0] q_ff   [NSTG];
   logic [QUOT_W-1:0] q_in   [NSTG];
   logic              stk_ff [NSTG];
   logic              stk_in [NSTG];
   logic              sgn_ff [NSTG];
   logic              sgn_in [NSTG];

   for (genvar s = 0; s < NSTG; s++) begin : g_stg
      logic [VOL_W-1:0]  rem_prev;
      logic [COF_W-1:0]  num_prev;
      logic [QUOT_W-1:0] q_prev;
      logic              stk_prev;
      logic              sgn_prev;
      logic [VOL_W:0]    trial;
      logic [VOL_W:0]    diff;
      logic              ge;

      if (s == 0) begin : g_first
         assign rem_prev = '0;
         assign num_prev = mag_in;
         assign q_prev   = '0;
         assign stk_prev = 1'b0;
         assign sgn_prev = sign_in;
      end else begin : g_next
         assign rem_prev = rem_ff[s-1];
         assign num_prev = num_ff[s-1];
         assign q_prev   = q_ff[s-1];
         assign stk_prev = stk_ff[s-1];
         assign sgn_prev = sgn_ff[s-1];
      end

      // shift in the next numerator bit, subtract when it fits
      assign trial     = {rem_prev, num_prev[COF_W-1]};
      assign diff      = trial - {1'b0, den_in[s]};
      assign ge        = trial >= {1'b0, den_in[s]};
      assign rem_in[s] = ge ? diff[VOL_W-1:0] : trial[VOL_W-1:0];
      assign num_in[s] = {num_prev[COF_W-2:0], 1'b0};
      assign q_in[s]   = {q_prev[QUOT_W-2:0], ge};
      assign stk_in[s] = stk_prev | q_prev[QUOT_W-1];
      assign sgn_in[s] = sgn_prev;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
         q_ff   <= q_in;
         stk_ff <= stk_in;
         sgn_ff <= sgn_in;
      end
   end

   assign quot_out.q2     = q_ff[NSTG-1];
   assign quot_out.sticky = stk_ff[NSTG-1];
   assign quot_out.neg    = sgn_ff[NSTG-1];

endmodule

### rtl/tsg_merge.sv
// ----------------------------------------------------------------------------
// Tetrahedron shape gradients: merge stage
// Round, clip and sign the three lane quotients and build one result.
// ----------------------------------------------------------------------------
module tsg_merge (
   input  tsg_pkg::tsg_quot_type     quot [3],
   input  logic [tsg_pkg::VOL_W-1:0] vol,
   input  logic [1:0]                idx,
   output tsg_pkg::tsg_rsp_type      rsp
);
   import tsg_pkg::*;

   localparam logic [QUOT_W-1:0] POS_LIM = {2'b00, {(GRAD_BITS-1){1'b1}}};
   localparam logic [QUOT_W-1:0] NEG_LIM = {2'b01, {(GRAD_BITS-1){1'b0}}};

   logic [QUOT_W-1:0]    rnd  [3];
   logic [QUOT_W-1:0]    lim  [3];
   logic [QUOT_W-1:0]    mag  [3];
   logic                 over [3];
   logic [GRAD_BITS-1:0] grad [3];
   logic                 degen;

   always_comb begin
      degen = (vol == '0);
      for (int k = 0; k < 3; k++) begin
         // last quotient bit is the rounding bit: ties go away from zero
         rnd[k]  = {1'b0, quot[k].q2[QUOT_W-1:1]} + QUOT_W'(quot[k].q2[0]);
         lim[k]  = quot[k].neg ? NEG_LIM : POS_LIM;
         over[k] = quot[k].sticky || (rnd[k] > lim[k]);
         mag[k]  = over[k] ? lim[k] : rnd[k];
         grad[k] = quot[k].neg ? GRAD_BITS'(~mag[k][GRAD_BITS-1:0] + GRAD_BITS'(1))
                               : mag[k][GRAD_BITS-1:0];
      end

      rsp.node_index = idx;
      rsp.grad_x     = degen ? '0 : grad[0];
      rsp.grad_y     = degen ? '0 : grad[1];
      rsp.grad_z     = degen ? '0 : grad[2];
      rsp.six_volume = (|vol[VOL_W-1:SIXV_BITS]) ? '1 : vol[SIXV_BITS-1:0];
      rsp.degenerate = degen;
      rsp.saturated  = !degen && (over[0] || over[1] || over[2]);
      rsp.last       = (idx == LAST_NODE);
   end

endmodule

### rtl/tetra_shape_gradients_unit.sv
// ----------------------------------------------------------------------------
// Tetrahedron shape gradients unit
// Shape function gradients and six-times volume of a linear tetrahedron,
// four results per element, one per corner.
// ----------------------------------------------------------------------------
//   port group | dir | transaction
//   req_       | in  | four corner coordinates of one element
//   rsp_       | out | gradients, volume and flags of one corner
//
// One element occupies the input register for all four corners, one corner
// per cycle while the pipeline advances, so a new element enters only as the
// last corner leaves; results leave at 1 per cycle unless stalled. A corner
// passes the input register, stages 1 to 5, the one-bit-per-stage divider
// lanes and output register. Reset (synchronous) clears the valid bits, the
// corner counter and divider control indices. A stalled result freezes the
// whole pipeline; the input register still takes a new element when empty.
// ----------------------------------------------------------------------------
module tetra_shape_gradients_unit #(
   parameter int FRAC_BITS = tsg_pkg::DEF_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tsg_pkg::tsg_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tsg_pkg::tsg_rsp_type rsp_data
);
   import tsg_pkg::*;

   localparam int NSTG = COF_W + FRAC_BITS + 1;

   function automatic logic [DIFF_W-1:0] dsub(logic [COORD_BITS-1:0] a,
                                             logic [COORD_BITS-1:0] b);
      return {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
   endfunction

   function automatic logic [PROD_W-1:0] smul(logic [DIFF_W-1:0] a,
                                             logic [DIFF_W-1:0] b);
      logic signed [PROD_W-1:0] r;
      r = $signed(a) * $signed(b);
      return r;
   endfunction

   function automatic logic [TERM_W-1:0] tmul(logic [DIFF_W-1:0] a,
                                             logic [COF_W-1:0] b);
      logic signed [TERM_W-1:0] r;
      r = $signed(a) * $signed(b);
      return r;
   endfunction

   // ---------------------------------------------------------------- control
   logic adv;
   logic accept;
   logic a_done;
   logic rsp_valid_ff;

   logic        a_valid_ff, a_valid_in;
   tsg_req_type a_item_ff, a_item_in;
   logic [1:0]  a_cnt_ff, a_cnt_in;

   // advance whenever the output register is empty or being taken
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign a_done    = a_valid_ff && adv && (a_cnt_ff == LAST_NODE);
   assign req_stall = a_valid_ff && !a_done;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      a_valid_in = a_valid_ff;
      a_item_in  = a_item_ff;
      a_cnt_in   = a_cnt_ff;
      if (a_valid_ff && adv) begin
         a_cnt_in = a_cnt_ff + 2'd1;
      end
      if (a_done) begin
         a_valid_in = 1'b0;
      end
      if (accept) begin
         a_valid_in = 1'b1;
         a_item_in  = req_data;
         a_cnt_in   = '0;
      end
   end

   // ------------------------------------------------- stage 1: differences
   logic [COORD_BITS-1:0] cx [4];
   logic [COORD_BITS-1:0] cy [4];
   logic [COORD_BITS-1:0] cz [4];
   logic [COORD_BITS-1:0] ca [3][4];
   logic [COORD_BITS-1:0] cb [3][4];
   logic [1:0]            o0, o1, o2;

   logic              s1_valid_ff, s1_valid_in;
   logic [1:0]        s1_idx_ff, s1_idx_in;
   logic [DIFF_W-1:0] s1_da_ff [3], s1_da_in [3];
   logic [DIFF_W-1:0] s1_db_ff [3], s1_db_in [3];
   logic [DIFF_W-1:0] s1_dc_ff [3], s1_dc_in [3];
   logic [DIFF_W-1:0] s1_dd_ff [3], s1_dd_in [3];
   logic              s1_neg_ff [3], s1_neg_in [3];
   logic [DIFF_W-1:0] s1_e_ff [3][3], s1_e_in [3][3];

   always_comb begin
      cx = '{a_item_ff.node0_x, a_item_ff.node1_x, a_item_ff.node2_x, a_item_ff.node3_x};
      cy = '{a_item_ff.node0_y, a_item_ff.node1_y, a_item_ff.node2_y, a_item_ff.node3_y};
      cz = '{a_item_ff.node0_z, a_item_ff.node1_z, a_item_ff.node2_z, a_item_ff.node3_z};
      // column pairs: x gradient uses (y,z), y uses (x,z), z uses (x,y)
      ca[0] = cy; cb[0] = cz;
      ca[1] = cx; cb[1] = cz;
      ca[2] = cx; cb[2] = cy;

      unique case (a_cnt_ff)
         2'd0:    begin o0 = 2'd1; o1 = 2'd2; o2 = 2'd3; end
         2'd1:    begin o0 = 2'd0; o1 = 2'd2; o2 = 2'd3; end
         2'd2:    begin o0 = 2'd0; o1 = 2'd1; o2 = 2'd3; end
         default: begin o0 = 2'd0; o1 = 2'd1; o2 = 2'd2; end
      endcase

      s1_valid_in = a_valid_ff;
      s1_idx_in   = a_cnt_ff;
      for (int k = 0; k < 3; k++) begin
         s1_da_in[k]  = dsub(ca[k][o1], ca[k][o0]);
         s1_db_in[k]  = dsub(cb[k][o2], cb[k][o0]);
         s1_dc_in[k]  = dsub(ca[k][o2], ca[k][o0]);
         s1_dd_in[k]  = dsub(cb[k][o1], cb[k][o0]);
         // even corners flip x and z, odd corners flip y
         s1_neg_in[k] = (k == 1) ? a_cnt_ff[0] : !a_cnt_ff[0];
      end
      for (int i = 0; i < 3; i++) begin
         s1_e_in[i][0] = dsub(cx[i+1], cx[0]);
         s1_e_in[i][1] = dsub(cy[i+1], cy[0]);
         s1_e_in[i][2] = dsub(cz[i+1], cz[0]);
      end
   end

   // ---------------------------------------------------- stage 2: products
   logic              s2_valid_ff;
   logic [1:0]        s2_idx_ff;
   logic [PROD_W-1:0] s2_p1_ff [3], s2_p1_in [3];
   logic [PROD_W-1:0] s2_p2_ff [3], s2_p2_in [3];
   logic [PROD_W-1:0] s2_ma_ff [3], s2_ma_in [3];
   logic [PROD_W-1:0] s2_mb_ff [3], s2_mb_in [3];
   logic              s2_neg_ff [3];
   logic [DIFF_W-1:0] s2_e0_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s2_p1_in[k] = smul(s1_da_ff[k], s1_db_ff[k]);
         s2_p2_in[k] = smul(s1_dc_ff[k], s1_dd_ff[k]);
      end
      s2_ma_in[0] = smul(s1_e_ff[1][1], s1_e_ff[2][2]);
      s2_mb_in[0] = smul(s1_e_ff[1][2], s1_e_ff[2][1]);
      s2_ma_in[1] = smul(s1_e_ff[1][0], s1_e_ff[2][2]);
      s2_mb_in[1] = smul(s1_e_ff[1][2], s1_e_ff[2][0]);
      s2_ma_in[2] = smul(s1_e_ff[1][0], s1_e_ff[2][1]);
      s2_mb_in[2] = smul(s1_e_ff[1][1], s1_e_ff[2][0]);
   end

   // ------------------------------------ stage 3: cofactors and minors
   logic             s3_valid_ff;
   logic [1:0]       s3_idx_ff;
   logic [COF_W-1:0] s3_cof_ff [3], s3_cof_in [3];
   logic [COF_W-1:0] s3_m_ff [3], s3_m_in [3];
   logic [DIFF_W-1:0] s3_e0_ff [3];
   logic [COF_W-1:0] cof_raw [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cof_raw[k]  = {s2_p1_ff[k][PROD_W-1], s2_p1_ff[k]}
                     - {s2_p2_ff[k][PROD_W-1], s2_p2_ff[k]};
         s3_cof_in[k] = s2_neg_ff[k] ? COF_W'(-cof_raw[k]) : cof_raw[k];
         s3_m_in[k]   = {s2_ma_ff[k][PROD_W-1], s2_ma_ff[k]}
                      - {s2_mb_ff[k][PROD_W-1], s2_mb_ff[k]};
      end
   end

   // ------------------------------- stage 4: volume terms, cofactor sign
   logic              s4_valid_ff;
   logic [1:0]        s4_idx_ff;
   logic [TERM_W-1:0] s4_t_ff [3], s4_t_in [3];
   logic [COF_W-1:0]  s4_mag_ff [3], s4_mag_in [3];
   logic              s4_sgn_ff [3], s4_sgn_in [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s4_t_in[k]   = tmul(s3_e0_ff[k], s3_m_ff[k]);
         s4_sgn_in[k] = s3_cof_ff[k][COF_W-1];
         s4_mag_in[k] = s4_sgn_in[k] ? COF_W'(-s3_cof_ff[k]) : s3_cof_ff[k];
      end
   end

   // ------------------------------------------------ stage 5: six volume
   logic             s5_valid_ff;
   logic [1:0]       s5_idx_ff;
   logic [COF_W-1:0] s5_mag_ff [3];
   logic             s5_sgn_ff [3];
   logic [VOL_W-1:0] s5_vol_ff, s5_vol_in;
   logic [DET_W-1:0] det;

   always_comb begin
      det = {{2{s4_t_ff[0][TERM_W-1]}}, s4_t_ff[0]}
          - {{2{s4_t_ff[1][TERM_W-1]}}, s4_t_ff[1]}
          + {{2{s4_t_ff[2][TERM_W-1]}}, s4_t_ff[2]};
      s5_vol_in = det[DET_W-1] ? VOL_W'(-det) : det[VOL_W-1:0];
   end

   // --------------------------------------------- front pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff  <= 1'b0;
         a_cnt_ff    <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         a_cnt_ff   <= a_cnt_in;
         if (adv) begin
            s1_valid_ff <= s1_valid_in;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
            s4_valid_ff <= s3_valid_ff;
            s5_valid_ff <= s4_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_item_ff <= a_item_in;
      if (adv) begin
         s1_idx_ff <= s1_idx_in;
         s1_da_ff  <= s1_da_in;
         s1_db_ff  <= s1_db_in;
         s1_dc_ff  <= s1_dc_in;
         s1_dd_ff  <= s1_dd_in;
         s1_neg_ff <= s1_neg_in;
         s1_e_ff   <= s1_e_in;

         s2_idx_ff <= s1_idx_ff;
         s2_p1_ff  <= s2_p1_in;
         s2_p2_ff  <= s2_p2_in;
         s2_ma_ff  <= s2_ma_in;
         s2_mb_ff  <= s2_mb_in;
         s2_neg_ff <= s1_neg_ff;
         s2_e0_ff  <= s1_e_ff[0];

         s3_idx_ff <= s2_idx_ff;
         s3_cof_ff <= s3_cof_in;
         s3_m_ff   <= s3_m_in;
         s3_e0_ff  <= s2_e0_ff;

         s4_idx_ff <= s3_idx_ff;
         s4_t_ff   <= s4_t_in;
         s4_mag_ff <= s4_mag_in;
         s4_sgn_ff <= s4_sgn_in;

         s5_idx_ff <= s4_idx_ff;
         s5_mag_ff <= s4_mag_ff;
         s5_sgn_ff <= s4_sgn_ff;
         s5_vol_ff <= s5_vol_in;
      end
   end

   // ----------------------------- divider lanes with shared divisor line
   logic [VOL_W-1:0] den_ff [NSTG];
   logic [VOL_W-1:0] den_lane [NSTG];
   tsg_ctl_type      ctl_ff [NSTG];
   tsg_quot_type     quot [3];

   // stage s of every lane divides by the divisor of the item it takes in
   for (genvar s = 0; s < NSTG; s++) begin : g_den
      if (s == 0) begin : g_head
         assign den_lane[s] = s5_vol_ff;
      end else begin : g_tail
         assign den_lane[s] = den_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff[0] <= s5_vol_ff;
         for (int s = 1; s < NSTG; s++) begin
            den_ff[s] <= den_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NSTG; s++) begin
            ctl_ff[s].valid <= 1'b0;
            ctl_ff[s].idx   <= '0;
         end
      end else if (adv) begin
         ctl_ff[0].valid <= s5_valid_ff;
         ctl_ff[0].idx   <= s5_idx_ff;
         for (int s = 1; s < NSTG; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_lane
      tsg_div_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock    (clock),
         .adv      (adv),
         .mag_in   (s5_mag_ff[k]),
         .sign_in  (s5_sgn_ff[k]),
         .den_in   (den_lane),
         .quot_out (quot[k])
      );
   end

   // ------------------------------------------------ merge and output
   tsg_rsp_type rsp_mrg;
   tsg_rsp_type rsp_ff;

   tsg_merge u_merge (
      .quot (quot),
      .vol  (den_ff[NSTG-1]),
      .idx  (ctl_ff[NSTG-1].idx),
      .rsp  (rsp_mrg)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= ctl_ff[NSTG-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_mrg;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ------------------------------------------------------- assertions
   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !a_valid_ff |-> !req_stall)
      else $error("input stalled with empty input register");

   a_hold_element: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && adv && (a_cnt_ff != LAST_NODE)) |=> a_valid_ff)
      else $error("element dropped before its last corner");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.degenerate) |->
         (!rsp_ff.saturated && (rsp_ff.grad_x == '0) && (rsp_ff.grad_y == '0)
          && (rsp_ff.grad_z == '0)))
      else $error("degenerate result carries nonzero gradients");

endmodule
